@@ design/ialu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the integer ALU with status flags: opcode
// encoding, flag group layouts and register file sizing.
// ----------------------------------------------------------------------------
package ialu_pkg;

  // Register file
  localparam int NUM_REGS = 16;
  localparam int RIDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int RNUM_W   = 4;   // width of register numbers in an item
  localparam int DATA_W   = 32;
  localparam int OP_W     = 5;

  // logb exponent field
  localparam int EXP_LSB   = 23;
  localparam int EXP_W     = 8;
  localparam int LOGB_BIAS = 127;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 5'd0,
    OP_SUB    = 5'd1,
    OP_ADDC   = 5'd2,
    OP_SUBC   = 5'd3,
    OP_AND    = 5'd4,
    OP_COMP   = 5'd5,
    OP_PASS   = 5'd6,
    OP_XOR    = 5'd7,
    OP_OR     = 5'd8,
    OP_INC    = 5'd9,
    OP_DEC    = 5'd10,
    OP_MAX    = 5'd11,
    OP_NEG    = 5'd12,
    OP_MUL    = 5'd13,
    OP_ADDSUB = 5'd14,
    OP_LOGB   = 5'd15,
    OP_LOAD   = 5'd16
  } op_t;

  // ALU status group: AC AV AN AZ
  typedef struct packed {
    logic ac;
    logic av;
    logic an;
    logic az;
  } alu_flags_t;

  // Multiplier status group: MU MV MN
  typedef struct packed {
    logic mu;
    logic mv;
    logic mn;
  } mul_flags_t;

endpackage

@@ design/integer_alu_with_status_flags_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_with_status_flags_unit
// 32-bit integer compute unit: register file, sticky ALU and multiplier
// flags, one instruction item in, one result item out.
// ----------------------------------------------------------------------------
// Path: an accepted item goes through the operand fetch register, then the
//   result register; a result-side stall holds it in either register.
// Throughput: one item per cycle unless out_stall holds the result register;
//   the execute stage writes back the register file and flags at the edge
//   where the next item's operands are fetched, with a writeback-to-fetch bypass.
// Reset: clears the register file, both flag groups and both stage valids.
module integer_alu_with_status_flags_unit (
  input  logic                       clk,
  input  logic                       rst,
  // instruction channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ialu_pkg::OP_W-1:0]   op,
  input  logic [ialu_pkg::RNUM_W-1:0] dest,
  input  logic [ialu_pkg::RNUM_W-1:0] dest2,
  input  logic [ialu_pkg::RNUM_W-1:0] src_a,
  input  logic [ialu_pkg::RNUM_W-1:0] src_b,
  input  logic [ialu_pkg::DATA_W-1:0] value,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ialu_pkg::DATA_W-1:0] result,
  output logic [ialu_pkg::DATA_W-1:0] result2,
  output logic                       flag_zero,
  output logic                       flag_negative,
  output logic                       flag_overflow,
  output logic                       flag_carry,
  output logic                       mul_negative,
  output logic                       mul_overflow,
  output logic                       mul_underflow
);
  import ialu_pkg::*;

  localparam logic [DATA_W-1:0] SIGN_MASK = {1'b1, {(DATA_W-1){1'b0}}};

  // Architectural state
  logic [DATA_W-1:0] regs [NUM_REGS];
  alu_flags_t        alu_flags;
  alu_flags_t        alu_flags_next;
  mul_flags_t        mul_flags;
  mul_flags_t        mul_flags_next;

  // Operand fetch stage
  logic              s1_valid;
  logic [OP_W-1:0]   s1_op;
  logic [RNUM_W-1:0] s1_dest;
  logic [RNUM_W-1:0] s1_dest2;
  logic [DATA_W-1:0] s1_value;
  logic [DATA_W-1:0] s1_a;
  logic [DATA_W-1:0] s1_b;

  // Execute / writeback
  logic              adv;
  logic              in_accept;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] res2;
  logic              wr0_en;
  logic              wr1_en;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;

  // Execute stage moves when the result register is free or draining
  assign adv       = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !adv;
  assign in_accept = in_valid && !in_stall;

  // Register read with bypass from this cycle's writeback
  function automatic logic [DATA_W-1:0] reg_read(
    input logic [RNUM_W-1:0] num,
    input logic              w0, input logic [RNUM_W-1:0] w0_idx,
    input logic [DATA_W-1:0] w0_data,
    input logic              w1, input logic [RNUM_W-1:0] w1_idx,
    input logic [DATA_W-1:0] w1_data,
    input logic [DATA_W-1:0] stored
  );
    logic [DATA_W-1:0] v;
    if (w1 && (w1_idx == num)) begin
      v = w1_data;
    end else if (w0 && (w0_idx == num)) begin
      v = w0_data;
    end else if (32'(num) < NUM_REGS) begin
      v = stored;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign rd_a = reg_read(src_a, wr0_en, s1_dest, res, wr1_en, s1_dest2, res2,
                         regs[RIDX_W'(src_a)]);
  assign rd_b = reg_read(src_b, wr0_en, s1_dest, res, wr1_en, s1_dest2, res2,
                         regs[RIDX_W'(src_b)]);

  // Operand fetch register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_op    <= op;
      s1_dest  <= dest;
      s1_dest2 <= dest2;
      s1_value <= value;
      s1_a     <= rd_a;
      s1_b     <= rd_b;
    end
  end

  // Execute: one pass of adders, logic, compare and multiply
  always_comb begin
    logic [DATA_W:0]     sum;
    logic [DATA_W:0]     diff;
    logic [DATA_W-1:0]   bop;
    logic                cin;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   hi;
    logic                lt_s;
    logic                sum_av;
    logic                diff_av;

    // main adder operand and carry-in
    bop = s1_b;
    cin = 1'b0;
    case (s1_op)
      OP_SUB:  begin bop = ~s1_b; cin = 1'b1;         end
      OP_ADDC: begin bop = s1_b;  cin = alu_flags.ac; end
      OP_SUBC: begin bop = ~s1_b; cin = alu_flags.ac; end
      OP_INC:  begin bop = DATA_W'(1); cin = 1'b0;    end
      OP_DEC:  begin bop = ~DATA_W'(1); cin = 1'b1;   end
      default: begin bop = s1_b;  cin = 1'b0;         end
    endcase
    sum  = {1'b0, s1_a} + {1'b0, bop} + (DATA_W+1)'(cin);
    diff = {1'b0, s1_a} + {1'b0, ~s1_b} + (DATA_W+1)'(1);
    sum_av  = ((~(s1_a ^ bop) & (s1_a ^ sum[DATA_W-1:0])) & SIGN_MASK) != '0;
    diff_av = ((~(s1_a ^ ~s1_b) & (s1_a ^ diff[DATA_W-1:0])) & SIGN_MASK) != '0;
    lt_s    = (s1_a ^ SIGN_MASK) < (s1_b ^ SIGN_MASK);
    prod    = {{DATA_W{1'b0}}, s1_a} * {{DATA_W{1'b0}}, s1_b};
    hi      = prod[2*DATA_W-1:DATA_W];

    res            = '0;
    res2           = '0;
    wr0_en         = 1'b0;
    wr1_en         = 1'b0;
    alu_flags_next = alu_flags;
    mul_flags_next = mul_flags;

    case (s1_op)
      OP_ADD, OP_SUB, OP_ADDC, OP_SUBC, OP_INC, OP_DEC: begin
        res            = sum[DATA_W-1:0];
        wr0_en         = 1'b1;
        alu_flags_next = '{ac: sum[DATA_W], av: sum_av, an: res[DATA_W-1],
                           az: (res == '0)};
      end
      OP_AND, OP_XOR, OP_OR, OP_PASS, OP_MAX, OP_LOGB: begin
        case (s1_op)
          OP_AND:  res = s1_a & s1_b;
          OP_XOR:  res = s1_a ^ s1_b;
          OP_OR:   res = s1_a | s1_b;
          OP_MAX:  res = lt_s || (s1_a == s1_b) ? s1_b : s1_a;
          OP_LOGB: res = DATA_W'(s1_a[EXP_LSB +: EXP_W]) - DATA_W'(LOGB_BIAS);
          default: res = s1_a;
        endcase
        wr0_en         = 1'b1;
        alu_flags_next = '{ac: 1'b0, av: 1'b0, an: res[DATA_W-1], az: (res == '0)};
      end
      OP_COMP: begin
        alu_flags_next = '{ac: 1'b0, av: 1'b0, an: lt_s, az: (s1_a == s1_b)};
      end
      OP_NEG: begin
        res            = '0 - s1_a;
        wr0_en         = 1'b1;
        alu_flags_next = '{ac: (s1_a == '0), av: (s1_a == SIGN_MASK),
                           an: res[DATA_W-1], az: (res == '0)};
      end
      OP_MUL: begin
        res            = prod[DATA_W-1:0];
        wr0_en         = 1'b1;
        mul_flags_next = '{mu: (hi == '0) && (res != '0),
                           mv: (hi != '0) && (hi != '1),
                           mn: res[DATA_W-1]};
      end
      OP_ADDSUB: begin
        res            = sum[DATA_W-1:0];
        res2           = diff[DATA_W-1:0];
        wr0_en         = 1'b1;
        wr1_en         = 1'b1;
        alu_flags_next = '{ac: sum[DATA_W] | diff[DATA_W],
                           av: sum_av | diff_av,
                           an: res[DATA_W-1] | res2[DATA_W-1],
                           az: (res == '0) || (res2 == '0)};
      end
      OP_LOAD: begin
        res    = s1_value;
        wr0_en = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase

    // writes only happen for an executing item and a register in the file
    wr0_en = wr0_en && adv && (32'(s1_dest) < NUM_REGS);
    wr1_en = wr1_en && adv && (32'(s1_dest2) < NUM_REGS);
  end

  // Register file and flag writeback; the difference wins on equal targets
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      alu_flags <= '0;
      mul_flags <= '0;
    end else begin
      if (wr0_en && !(wr1_en && (s1_dest2 == s1_dest))) begin
        regs[RIDX_W'(s1_dest)] <= res;
      end
      if (wr1_en) begin
        regs[RIDX_W'(s1_dest2)] <= res2;
      end
      if (adv) begin
        alu_flags <= alu_flags_next;
        mul_flags <= mul_flags_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      result        <= res;
      result2       <= res2;
      flag_zero     <= alu_flags_next.az;
      flag_negative <= alu_flags_next.an;
      flag_overflow <= alu_flags_next.av;
      flag_carry    <= alu_flags_next.ac;
      mul_negative  <= mul_flags_next.mn;
      mul_overflow  <= mul_flags_next.mv;
      mul_underflow <= mul_flags_next.mu;
    end
  end

  // Assertions
  a_reset_flags: assert property (@(posedge clk)
    rst |=> (alu_flags == '0) && (mul_flags == '0))
    else $error("flags not cleared by reset");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled without a held item");

  a_mul_flags_kept: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_op != OP_MUL) |=> $stable(mul_flags))
    else $error("multiplier flags changed by a non-multiply item");

  a_load_keeps_alu: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_op == OP_LOAD) |=> $stable(alu_flags))
    else $error("ALU flags changed by load");

  a_comp_result_zero: assert property (@(posedge clk) disable iff (rst)
    adv && (s1_op == OP_COMP) |=> out_valid && (result == '0) && (result2 == '0))
    else $error("compare produced a nonzero result");

  a_outputs_match_flags: assert property (@(posedge clk) disable iff (rst)
    $past(adv) |-> (flag_carry == alu_flags.ac) && (flag_zero == alu_flags.az)
                   && (mul_overflow == mul_flags.mv))
    else $error("reported flags differ from flag state");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the integer ALU with status flags against a cycle-free predictor of
// its register file, ALU flags and multiplier flags. A directed set of
// instructions hits flag corner cases, then random instruction streams run
// with bursty issue and a changing result-side stall pattern.
// ----------------------------------------------------------------------------
module testbench;
  import ialu_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 5'd17;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 5'd31;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic [OP_W-1:0]   opc;
    logic [RNUM_W-1:0] dest;
    logic [RNUM_W-1:0] dest2;
    logic [RNUM_W-1:0] src_a;
    logic [RNUM_W-1:0] src_b;
    logic [DATA_W-1:0] value;
    bit                drain_first;  // wait for all results before issuing
  } instr_t;

  typedef struct {
    logic [DATA_W-1:0] result;
    logic [DATA_W-1:0] result2;
    alu_flags_t        alu;
    mul_flags_t        mul;
  } alu_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     op        = '0;
  logic [RNUM_W-1:0]   dest      = '0;
  logic [RNUM_W-1:0]   dest2     = '0;
  logic [RNUM_W-1:0]   src_a     = '0;
  logic [RNUM_W-1:0]   src_b     = '0;
  logic [DATA_W-1:0]   value     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DATA_W-1:0]   result;
  logic [DATA_W-1:0]   result2;
  logic                flag_zero;
  logic                flag_negative;
  logic                flag_overflow;
  logic                flag_carry;
  logic                mul_negative;
  logic                mul_overflow;
  logic                mul_underflow;

  integer_alu_with_status_flags_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .dest          (dest),
    .dest2         (dest2),
    .src_a         (src_a),
    .src_b         (src_b),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result        (result),
    .result2       (result2),
    .flag_zero     (flag_zero),
    .flag_negative (flag_negative),
    .flag_overflow (flag_overflow),
    .flag_carry    (flag_carry),
    .mul_negative  (mul_negative),
    .mul_overflow  (mul_overflow),
    .mul_underflow (mul_underflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted machine state
  logic [DATA_W-1:0] gpr [NUM_REGS];
  alu_flags_t        alu_st = '0;
  mul_flags_t        mul_st = '0;

  instr_t       instr_q[$];
  alu_outcome_t outcome_q[$];

  int          n_accepted  = 0;
  int          n_checked   = 0;
  int          n_errors    = 0;
  int          total_items = 0;
  logic [31:0] op_seen     = '0;

  initial begin
    for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
  end

  function automatic logic [DATA_W-1:0] read_reg(input logic [RNUM_W-1:0] idx);
    return (idx < NUM_REGS) ? gpr[idx] : '0;
  endfunction

  function automatic void write_reg(input logic [RNUM_W-1:0] idx,
                                    input logic [DATA_W-1:0] v);
    if (idx < NUM_REGS) gpr[idx] = v;
  endfunction

  function automatic alu_flags_t zn_flags(input logic [DATA_W-1:0] r);
    alu_flags_t f;
    f    = '0;
    f.az = (r == '0);
    f.an = r[DATA_W-1];
    return f;
  endfunction

  // a + b + cin, with AZ AN AV AC
  function automatic logic [DATA_W-1:0] add_flags(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b,
                                                  input logic cin,
                                                  output alu_flags_t f);
    logic [DATA_W:0] s;
    s    = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
    f    = zn_flags(s[DATA_W-1:0]);
    f.av = ~(a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ s[DATA_W-1]);
    f.ac = s[DATA_W];
    return s[DATA_W-1:0];
  endfunction

  // Execute one instruction on the predicted state and queue its outcome
  function automatic void execute_instr(input instr_t it);
    logic [DATA_W-1:0]   a, b, res, res2, lo, hi;
    logic [2*DATA_W-1:0] p;
    alu_flags_t          f, f2;
    alu_outcome_t        o;
    a    = read_reg(it.src_a);
    b    = read_reg(it.src_b);
    res  = '0;
    res2 = '0;
    op_seen[it.opc] = 1'b1;
    case (it.opc)
      OP_ADD: begin
        res = add_flags(a, b, 1'b0, f);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_SUB: begin
        res = add_flags(a, ~b, 1'b1, f);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_ADDC: begin
        res = add_flags(a, b, alu_st.ac, f);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_SUBC: begin
        res = add_flags(a, ~b, alu_st.ac, f);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_AND: begin
        res = a & b; write_reg(it.dest, res); alu_st = zn_flags(res);
      end
      OP_COMP: begin
        f    = '0;
        f.az = (a == b);
        f.an = ($signed(a) < $signed(b));
        alu_st = f;
      end
      OP_PASS: begin
        res = a; write_reg(it.dest, res); alu_st = zn_flags(res);
      end
      OP_XOR: begin
        res = a ^ b; write_reg(it.dest, res); alu_st = zn_flags(res);
      end
      OP_OR: begin
        res = a | b; write_reg(it.dest, res); alu_st = zn_flags(res);
      end
      OP_INC: begin
        res = add_flags(a, 32'd1, 1'b0, f);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_DEC: begin
        res = add_flags(a, ~32'd1, 1'b1, f);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_MAX: begin
        res = ($signed(a) > $signed(b)) ? a : b;
        write_reg(it.dest, res); alu_st = zn_flags(res);
      end
      OP_NEG: begin
        res  = '0 - a;
        f    = zn_flags(res);
        f.av = (a == 32'h8000_0000);
        f.ac = (a == '0);
        write_reg(it.dest, res); alu_st = f;
      end
      OP_MUL: begin
        p  = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
        lo = p[DATA_W-1:0];
        hi = p[2*DATA_W-1:DATA_W];
        mul_st.mn = lo[DATA_W-1];
        mul_st.mv = (hi != '0) && (hi != '1);
        mul_st.mu = (hi == '0) && (lo != '0);
        res = lo; write_reg(it.dest, res);
      end
      OP_ADDSUB: begin
        // both halves read the old sources; the difference wins on dest == dest2
        res  = add_flags(a, b, 1'b0, f);
        res2 = add_flags(a, ~b, 1'b1, f2);
        write_reg(it.dest, res);
        write_reg(it.dest2, res2);
        alu_st = f | f2;
      end
      OP_LOGB: begin
        res = 32'(a[EXP_LSB +: EXP_W]) - 32'(LOGB_BIAS);
        write_reg(it.dest, res); alu_st = zn_flags(res);
      end
      OP_LOAD: begin
        res = it.value; write_reg(it.dest, res);
      end
      default: ;  // unused codes leave everything alone
    endcase
    o.result  = res;
    o.result2 = res2;
    o.alu     = alu_st;
    o.mul     = mul_st;
    outcome_q.push_back(o);
  endfunction

  function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                      input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // Issue side: bursts with random gaps, optional drain before an item
  int     burst_left = 1;
  int     gap_left   = 0;
  instr_t cur_instr;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        execute_instr(cur_instr);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (instr_q.size() == 0 ||
                     (instr_q[0].drain_first && outcome_q.size() != 0)) begin
          in_valid <= 1'b0;
        end else begin
          cur_instr = instr_q.pop_front();
          op       <= cur_instr.opc;
          dest     <= cur_instr.dest;
          dest2    <= cur_instr.dest2;
          src_a    <= cur_instr.src_a;
          src_b    <= cur_instr.src_b;
          value    <= cur_instr.value;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20)
                                                     : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // Result side: compare with the oldest prediction, stall on a shifting pattern
  int          stall_span = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always @(posedge clk) begin
    alu_outcome_t exp_o;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result arrived with no instruction outstanding: result %h", result);
          n_errors++;
        end else begin
          exp_o = outcome_q.pop_front();
          n_checked++;
          check_field("result", exp_o.result, result);
          check_field("result2", exp_o.result2, result2);
          check_field("flag_zero", DATA_W'(exp_o.alu.az), DATA_W'(flag_zero));
          check_field("flag_negative", DATA_W'(exp_o.alu.an), DATA_W'(flag_negative));
          check_field("flag_overflow", DATA_W'(exp_o.alu.av), DATA_W'(flag_overflow));
          check_field("flag_carry", DATA_W'(exp_o.alu.ac), DATA_W'(flag_carry));
          check_field("mul_negative", DATA_W'(exp_o.mul.mn), DATA_W'(mul_negative));
          check_field("mul_overflow", DATA_W'(exp_o.mul.mv), DATA_W'(mul_overflow));
          check_field("mul_underflow", DATA_W'(exp_o.mul.mu), DATA_W'(mul_underflow));
        end
      end
      if (stall_span == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_span = $urandom_range(8, 120);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= stall_span[1];
      endcase
    end
  end

  task automatic add_instr(input logic [OP_W-1:0] opc, input logic [RNUM_W-1:0] d,
                           input logic [RNUM_W-1:0] d2, input logic [RNUM_W-1:0] sa,
                           input logic [RNUM_W-1:0] sb, input logic [DATA_W-1:0] v,
                           input bit drain);
    instr_t it;
    it.opc         = opc;
    it.dest        = d;
    it.dest2       = d2;
    it.src_a       = sa;
    it.src_b       = sb;
    it.value       = v;
    it.drain_first = drain;
    instr_q.push_back(it);
  endtask

  // Load words that land on flag edges more often than plain random ones
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'hffff_ffff;
      4:       return $urandom_range(0, 255);
      5:       return {1'($urandom_range(0, 1)), 8'($urandom), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [OP_W-1:0] opc;
    int              pick;

    // Directed: operands at the signed and unsigned edges
    add_instr(OP_LOAD,   0,  0, 0, 0, 32'h7fff_ffff, 1'b0);
    add_instr(OP_LOAD,   1,  0, 0, 0, 32'h8000_0000, 1'b0);
    add_instr(OP_LOAD,   2,  0, 0, 0, 32'hffff_ffff, 1'b0);
    add_instr(OP_LOAD,   3,  0, 0, 0, 32'h0000_0001, 1'b0);
    add_instr(OP_ADD,    4,  0, 0, 3, 32'h0, 1'b0);          // signed overflow
    add_instr(OP_ADD,    5,  0, 2, 2, 32'h0, 1'b0);          // carry out
    add_instr(OP_SUB,    6,  0, 3, 3, 32'h0, 1'b0);          // zero, no borrow
    add_instr(OP_ADDC,   8,  0, 2, 3, 32'h0, 1'b0);          // carry in used
    add_instr(OP_SUBC,   9,  0, 3, 2, 32'h0, 1'b0);
    add_instr(OP_AND,   10,  0, 0, 1, 32'h0, 1'b0);
    add_instr(OP_OR,    10,  0, 0, 1, 32'h0, 1'b0);
    add_instr(OP_XOR,   11,  0, 2, 2, 32'h0, 1'b0);
    add_instr(OP_PASS,  12,  0, 1, 0, 32'h0, 1'b0);
    add_instr(OP_COMP,   0,  0, 1, 0, 32'h0, 1'b0);          // less than, signed
    add_instr(OP_COMP,   0,  0, 2, 2, 32'h0, 1'b0);          // equal
    add_instr(OP_INC,   13,  0, 0, 0, 32'h0, 1'b0);          // overflow on inc
    add_instr(OP_DEC,   14,  0, 1, 0, 32'h0, 1'b0);          // overflow on dec
    add_instr(OP_MAX,   12,  0, 0, 1, 32'h0, 1'b0);
    add_instr(OP_NEG,   13,  0, 1, 0, 32'h0, 1'b0);          // most negative word
    add_instr(OP_NEG,   14,  0, 15, 0, 32'h0, 1'b0);         // zero sets carry
    add_instr(OP_MUL,    5,  0, 2, 2, 32'h0, 1'b0);          // high word overflow
    add_instr(OP_MUL,    6,  0, 3, 0, 32'h0, 1'b0);          // high word zero
    add_instr(OP_ADDSUB, 7,  7, 1, 3, 32'h0, 1'b0);          // same destination
    add_instr(OP_ADDSUB, 3,  4, 3, 0, 32'h0, 1'b0);          // dest is a source
    add_instr(OP_LOGB,   8,  0, 0, 0, 32'h0, 1'b0);
    add_instr(OP_LOGB,   9,  0, 15, 0, 32'h0, 1'b0);
    add_instr(OP_UNUSED_LAST, 0, 0, 0, 0, 32'hffff_ffff, 1'b0);

    // Random: loads keep register contents varied, a few unused codes mixed in
    for (int i = 0; i < 950; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        opc = OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      else if (pick < 24)
        opc = OP_LOAD;
      else
        opc = OP_W'($urandom_range(OP_ADD, OP_LOGB));
      add_instr(opc, RNUM_W'($urandom), RNUM_W'($urandom), RNUM_W'($urandom),
                RNUM_W'($urandom),
                (opc == OP_LOAD) ? pick_word() : $urandom,
                (i == 300) || (i == 700));
    end
    total_items = instr_q.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < total_items || outcome_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d instructions over %0d opcodes; %0d results compared.",
             n_accepted, $countones(op_seen), n_checked);
    if (n_errors == 0) begin
      $display("PASS integer_alu_with_status_flags_unit");
    end else begin
      $display("FAIL integer_alu_with_status_flags_unit");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", outcome_q.size());
    $display("FAIL integer_alu_with_status_flags_unit");
    $finish;
  end

endmodule
